@@ hdl/rcbh_pkg.sv @@
// Package: shared types and constants of the hopping radio-control receiver.
package rcbh_pkg;

  // Protocol phase of the receiver.
  typedef enum logic [1:0] {
    PH_BIND = 2'd0,
    PH_ACK  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  // Command passed from the front end to the result sequencer.
  typedef enum logic [1:0] {
    OP_BIND       = 2'd0,
    OP_ACK        = 2'd1,
    OP_HOP        = 2'd2,
    OP_HOP_DECODE = 2'd3
  } cmd_op_t;

  // Result kinds.
  localparam logic [1:0] KIND_BIND = 2'd0;
  localparam logic [1:0] KIND_TUNE = 2'd1;
  localparam logic [1:0] KIND_TX   = 2'd2;
  localparam logic [1:0] KIND_CTRL = 2'd3;

  // Control indexes.
  localparam logic [3:0] CTL_ROLL     = 4'd0;
  localparam logic [3:0] CTL_PITCH    = 4'd1;
  localparam logic [3:0] CTL_THROTTLE = 4'd2;
  localparam logic [3:0] CTL_YAW      = 4'd3;
  localparam logic [3:0] CTL_RATE     = 4'd4;
  localparam logic [3:0] CTL_FLIP     = 4'd5;
  localparam logic [3:0] CTL_PICTURE  = 4'd6;
  localparam logic [3:0] CTL_VIDEO    = 4'd7;
  localparam logic [3:0] CTL_HEADLESS = 4'd8;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_VARIANT   = 2'd0;
  localparam logic [1:0] REG_PULSE_MIN = 2'd1;
  localparam logic [1:0] REG_PULSE_MAX = 2'd2;
  localparam logic [1:0] REG_PULSE_MID = 2'd3;

  localparam logic [11:0] PULSE_MIN_RST = 12'd1000;
  localparam logic [11:0] PULSE_MAX_RST = 12'd2000;
  localparam logic [11:0] PULSE_MID_RST = 12'd1500;

  // Packet buffer and protocol constants.
  localparam int          PKT_DEPTH     = 20;
  localparam logic [4:0]  PKT_LIMIT     = 5'd20;
  localparam logic [4:0]  SIZE_SHORT    = 5'd15;
  localparam logic [4:0]  SIZE_LONG     = 5'd19;
  localparam logic [31:0] TIMEOUT_SHORT = 32'd1500;
  localparam logic [31:0] TIMEOUT_LONG  = 32'd6500;
  localparam int          WIN_BYTES     = 10;
  localparam int          WIN_BASE      = 5;
  localparam int          WIN_BASE_LONG = 9;
  localparam logic [7:0]  BIND_MARK     = 8'haa;
  localparam logic [6:0]  HOP_BASE0     = 7'h03;
  localparam logic [6:0]  HOP_BASE1     = 7'h16;
  localparam logic [6:0]  HOP_BASE2     = 7'h2d;
  localparam logic [6:0]  HOP_BASE3     = 7'h40;
  localparam logic [7:0]  NIBBLE_MASK   = 8'h0f;
  localparam logic [7:0]  STICK_MASK    = 8'h7f;
  localparam logic [7:0]  RATE_MASK     = 8'h03;
  localparam logic [7:0]  FLIP_MASK     = 8'h10;
  localparam logic [7:0]  PICTURE_MASK  = 8'h04;
  localparam logic [7:0]  VIDEO_MASK    = 8'h02;
  localparam logic [7:0]  HEADLESS_MASK = 8'h04;

  typedef struct packed {
    cmd_op_t                 op;
    logic                    ack_final;
    logic [3:0][6:0]         ch;
    logic [WIN_BYTES-1:0][7:0] pkt;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  rf_channel;
    logic [3:0]  control_index;
    logic [15:0] control_value;
    logic        last;
  } result_t;

endpackage

@@ hdl/rcbh_front.sv @@
// Front end: accepts ticks and bytes, runs the protocol phases, issues commands.
module rcbh_front #(
  parameter int ACK_ROUNDS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          func,
  input  logic [7:0]    data_byte,
  input  logic          end_of_packet,
  input  logic          check_ok,
  input  logic [31:0]   now_us,
  input  logic          variant,
  input  logic          queue_full,
  output logic          push,
  output rcbh_pkg::cmd_t cmd
);
  import rcbh_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  ack_rounds, ack_rounds_next;
  logic [3:0][6:0] hop_table, hop_table_next;
  logic [1:0]  hop_position, hop_position_next;
  logic [31:0] last_hop_time, last_hop_time_next;
  logic [4:0]  byte_position, byte_position_next;
  logic [7:0]  packet_bytes [PKT_DEPTH];

  logic        acc, wr, pkt_valid, bind_hit, timed_out, ack_final;
  logic [4:0]  count, size;
  logic [31:0] timeout;
  logic [1:0]  hop_inc;
  logic [7:0]  view [PKT_DEPTH];

  assign in_ready = !queue_full;
  assign acc      = in_valid && in_ready;
  assign wr       = byte_position < PKT_LIMIT;
  assign count    = wr ? byte_position + 5'd1 : byte_position;
  assign size     = variant ? SIZE_LONG : SIZE_SHORT;
  assign timeout  = variant ? TIMEOUT_LONG : TIMEOUT_SHORT;
  assign pkt_valid = func && end_of_packet && check_ok && (count >= size);
  assign bind_hit  = pkt_valid && (view[0] == BIND_MARK);
  assign timed_out = (now_us - last_hop_time) > timeout;
  assign ack_final = ack_rounds >= 4'(ACK_ROUNDS);
  assign hop_inc   = hop_position + 2'd1;

  // Buffer contents as they stand after this byte is stored.
  always_comb begin
    for (int i = 0; i < PKT_DEPTH; i++) begin
      view[i] = (func && wr && byte_position == 5'(i)) ? data_byte : packet_bytes[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PKT_DEPTH; i++) begin
      if (acc && func && wr && byte_position == 5'(i)) begin
        packet_bytes[i] <= data_byte;
      end
    end
  end

  // Next phase.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_ACK: begin
        if (acc && !func && ack_final) phase_next = PH_DATA;
      end
      PH_DATA: phase_next = PH_DATA;
      default: begin
        if (acc && bind_hit) phase_next = PH_ACK;
      end
    endcase
  end

  // State updates and command issue.
  always_comb begin
    ack_rounds_next    = ack_rounds;
    hop_table_next     = hop_table;
    hop_position_next  = hop_position;
    last_hop_time_next = last_hop_time;
    byte_position_next = byte_position;
    push               = 1'b0;
    cmd.op             = OP_BIND;
    cmd.ack_final      = ack_final;
    cmd.ch             = hop_table;
    for (int k = 0; k < WIN_BYTES; k++) begin
      cmd.pkt[k] = variant ? view[k + WIN_BASE_LONG] : view[k + WIN_BASE];
    end
    if (acc) begin
      if (func) begin
        byte_position_next = count;
        if (end_of_packet) byte_position_next = 5'd0;
        unique case (phase)
          PH_ACK: ;
          PH_DATA: begin
            if (pkt_valid) begin
              hop_position_next  = hop_inc;
              last_hop_time_next = now_us;
              push               = 1'b1;
              cmd.op             = OP_HOP_DECODE;
              cmd.ch[0]          = hop_table[hop_inc];
            end
          end
          default: begin
            if (bind_hit) begin
              hop_table_next[0] = HOP_BASE0 + 7'(view[1] & NIBBLE_MASK);
              hop_table_next[1] = HOP_BASE1 + 7'(view[1] >> 4);
              hop_table_next[2] = HOP_BASE2 + 7'(view[2] & NIBBLE_MASK);
              hop_table_next[3] = HOP_BASE3 + 7'(view[2] >> 4);
              hop_position_next = 2'd0;
              ack_rounds_next   = 4'd0;
              push              = 1'b1;
              cmd.op            = OP_BIND;
            end
          end
        endcase
      end else begin
        unique case (phase)
          PH_ACK: begin
            push   = 1'b1;
            cmd.op = OP_ACK;
            if (ack_final) hop_position_next = 2'd0;
            else ack_rounds_next = ack_rounds + 4'd1;
          end
          PH_DATA: begin
            if (timed_out) begin
              hop_position_next  = hop_inc;
              last_hop_time_next = now_us;
              push               = 1'b1;
              cmd.op             = OP_HOP;
              cmd.ch[0]          = hop_table[hop_inc];
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_BIND;
      ack_rounds    <= 4'd0;
      hop_table     <= '0;
      hop_position  <= 2'd0;
      last_hop_time <= 32'd0;
      byte_position <= 5'd0;
    end else begin
      phase         <= phase_next;
      ack_rounds    <= ack_rounds_next;
      hop_table     <= hop_table_next;
      hop_position  <= hop_position_next;
      last_hop_time <= last_hop_time_next;
      byte_position <= byte_position_next;
    end
  end

  a_bpos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= PKT_LIMIT) else $error("byte position past buffer end");

endmodule

@@ hdl/rcbh_cmd_fifo.sv @@
// Command queue between the front end and the result sequencer.
module rcbh_cmd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rcbh_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output rcbh_pkg::cmd_t head
);
  import rcbh_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign valid = count != '0;
  assign head  = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop) rd_ptr <= bump(rd_ptr);
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop) else $error("command pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid) else $error("command popped from empty queue");

endmodule

@@ hdl/rcbh_back.sv @@
// Result sequencer: expands commands into results, one per unstalled cycle.
module rcbh_back #(
  parameter int BIND_CHANNEL = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  rcbh_pkg::cmd_t    cmd,
  output logic              pop,
  input  logic [11:0]       pulse_min,
  input  logic [11:0]       pulse_max,
  input  logic [11:0]       pulse_mid,
  output logic              out_valid,
  input  logic              out_ready,
  output rcbh_pkg::result_t res
);
  import rcbh_pkg::*;

  logic [3:0]  step, step_next, nres, idx;
  logic        load, is_last;
  logic [15:0] pulse_sum, value;
  logic [15:0] stick0, stick1, stick2, stick3;
  logic [15:0] vmin, vmid, vmax;
  result_t     res_next;

  function automatic logic [15:0] stick(input logic [7:0] lo, input logic [7:0] hi);
    return {1'b0, 7'(hi & STICK_MASK), lo};
  endfunction

  assign vmin      = {4'd0, pulse_min};
  assign vmid      = {4'd0, pulse_mid};
  assign vmax      = {4'd0, pulse_max};
  assign pulse_sum = vmax + vmin;
  assign stick0    = stick(cmd.pkt[0], cmd.pkt[1]);
  assign stick1    = stick(cmd.pkt[2], cmd.pkt[3]);
  assign stick2    = stick(cmd.pkt[4], cmd.pkt[5]);
  assign stick3    = stick(cmd.pkt[6], cmd.pkt[7]);
  assign idx       = step - 4'd1;

  always_comb begin
    unique case (cmd.op)
      OP_ACK:        nres = cmd.ack_final ? 4'd6 : 4'd5;
      OP_HOP_DECODE: nres = 4'd10;
      default:       nres = 4'd1;
    endcase
  end

  assign is_last   = step == nres - 4'd1;
  assign load      = cmd_valid && (!out_valid || out_ready);
  assign pop       = load && is_last;
  assign step_next = is_last ? 4'd0 : step + 4'd1;

  // Control values; window byte 0 is packet byte five, or nine if variant.
  always_comb begin
    case (idx)
      CTL_ROLL:     value = pulse_sum - stick0;
      CTL_PITCH:    value = pulse_sum - stick1;
      CTL_THROTTLE: value = stick2;
      CTL_YAW:      value = stick3;
      CTL_RATE: begin
        case (cmd.pkt[8] & RATE_MASK)
          8'd0:    value = vmin;
          8'd1:    value = vmid;
          default: value = vmax;
        endcase
      end
      CTL_FLIP:     value = ((cmd.pkt[7] & FLIP_MASK) != 8'd0) ? vmax : vmin;
      CTL_PICTURE:  value = ((cmd.pkt[9] & PICTURE_MASK) != 8'd0) ? vmax : vmin;
      CTL_VIDEO:    value = ((cmd.pkt[9] & VIDEO_MASK) != 8'd0) ? vmax : vmin;
      CTL_HEADLESS: value = ((cmd.pkt[8] & HEADLESS_MASK) != 8'd0) ? vmax : vmin;
      default:      value = 16'd0;
    endcase
  end

  always_comb begin
    res_next      = '0;
    res_next.last = is_last;
    unique case (cmd.op)
      OP_BIND: res_next.kind = KIND_BIND;
      OP_HOP: begin
        res_next.kind       = KIND_TUNE;
        res_next.rf_channel = cmd.ch[0];
      end
      OP_ACK: begin
        if (step == 4'd0) begin
          res_next.kind       = KIND_TX;
          res_next.rf_channel = 7'(BIND_CHANNEL);
        end else if (step == 4'd5) begin
          res_next.kind       = KIND_TUNE;
          res_next.rf_channel = cmd.ch[0];
        end else begin
          res_next.kind       = KIND_TX;
          res_next.rf_channel = cmd.ch[idx[1:0]];
        end
      end
      default: begin
        if (step == 4'd0) begin
          res_next.kind       = KIND_TUNE;
          res_next.rf_channel = cmd.ch[0];
        end else begin
          res_next.kind          = KIND_CTRL;
          res_next.control_index = idx;
          res_next.control_value = value;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= 4'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= step_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> step < nres) else $error("result step past command length");
  a_step_held: assert property (@(posedge clk) disable iff (rst)
    step != 4'd0 |-> cmd_valid) else $error("partly expanded command lost");

endmodule

@@ hdl/rc_radio_bind_hop_receiver.sv @@
// Top level: hopping radio-control receiver with stream ports and APB registers.
//
//  channel   dir  handshake                    content
//  s_*       in   s_tvalid / s_tready          tick or payload byte, check flag, time
//  m_*       out  m_tvalid / m_tready          bind, tune, transmit, control results
//  apb       in   psel & penable & pwrite      variant, pulse_min, pulse_max, pulse_mid
//
//  Cycles: the front end classifies one transfer per cycle while the command queue
//  has room; the sequencer issues one result per cycle while m_tready does not stall
//  it, and an item yields as many results as its command has (1, 5, 6 or 10), or none.
//  The first result passes the queue write, then the output register, before it
//  transfers. The sequencer's output register sets the rate.
//  Reset: synchronous, clears phase, counters, hop table, queue and output valid.
//  Stalls: a stalled m_tready holds the output register; input stalls only when
//  the two-entry command queue is full.
module rc_radio_bind_hop_receiver #(
  parameter int ACK_ROUNDS   = 8,
  parameter int BIND_CHANNEL = 2
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // data_byte[7:0], check_ok[8], now_us[40:9], zero
  input  logic        s_tuser,   // func: 0 timer tick, 1 payload byte
  input  logic        s_tlast,   // end_of_packet
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // rf_channel[6:0], control_index[10:7],
                                 // control_value[26:11], zero
  output logic [1:0]  m_tuser,   // kind: 0 bind, 1 tune, 2 transmit, 3 control value
  output logic        m_tlast,   // last result of the item
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rcbh_pkg::*;

  logic        variant;
  logic [11:0] pulse_min, pulse_max, pulse_mid;
  logic        cfg_wr;
  logic        push, queue_full, pop, cmd_valid;
  cmd_t        push_cmd, head;
  result_t     res;

  // Register file: write on the access phase, read straight from the registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      variant   <= 1'b0;
      pulse_min <= PULSE_MIN_RST;
      pulse_max <= PULSE_MAX_RST;
      pulse_mid <= PULSE_MID_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_VARIANT:   variant   <= pwdata[0];
        REG_PULSE_MIN: pulse_min <= pwdata[11:0];
        REG_PULSE_MAX: pulse_max <= pwdata[11:0];
        default:       pulse_mid <= pwdata[11:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_VARIANT:   prdata = {31'd0, variant};
      REG_PULSE_MIN: prdata = {20'd0, pulse_min};
      REG_PULSE_MAX: prdata = {20'd0, pulse_max};
      default:       prdata = {20'd0, pulse_mid};
    endcase
  end

  // Front end: protocol phases, packet buffer, hop bookkeeping.
  rcbh_front #(
    .ACK_ROUNDS (ACK_ROUNDS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .func          (s_tuser),
    .data_byte     (s_tdata[7:0]),
    .end_of_packet (s_tlast),
    .check_ok      (s_tdata[8]),
    .now_us        (s_tdata[40:9]),
    .variant       (variant),
    .queue_full    (queue_full),
    .push          (push),
    .cmd           (push_cmd)
  );

  // Commands carry a snapshot of the hop table and packet window, so the front
  // end may take the next packet while the sequencer still expands this one.
  rcbh_cmd_fifo #(
    .DEPTH (2)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .valid    (cmd_valid),
    .head     (head)
  );

  rcbh_back #(
    .BIND_CHANNEL (BIND_CHANNEL)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (head),
    .pop       (pop),
    .pulse_min (pulse_min),
    .pulse_max (pulse_max),
    .pulse_mid (pulse_mid),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {5'd0, res.control_value, res.control_index, res.rf_channel};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule
